FILE: src/pdlm_pkg.sv
// pdlm_pkg: shared types and constants of the power and data line master
// used by pdlm_tick_core and power_data_line_master; no dependencies

package pdlm_pkg;

  // transmit queue depth default
  localparam int unsigned PdlmTxDepth = 32;

  // slot lengths in 10 us ticks
  localparam logic [6:0] Ticks80us  = 7'd8;
  localparam logic [6:0] Ticks160us = 7'd16;
  localparam logic [6:0] Ticks220us = 7'd22;
  localparam logic [6:0] Ticks280us = 7'd28;
  localparam logic [6:0] Ticks380us = 7'd38;
  localparam logic [6:0] Ticks520us = 7'd52;
  localparam logic [6:0] Ticks600us = 7'd60;
  localparam logic [6:0] TimerStop  = 7'd0;

  localparam logic [7:0] StartByte     = 8'h55;
  localparam logic [7:0] FalseByte     = 8'hFF;
  localparam logic [4:0] FalseCountMax = 5'd31;

  // configuration reset values
  localparam logic [7:0] DefPeriodTicks = 8'd62;
  localparam logic [2:0] DefOnPeriods   = 3'd4;
  localparam logic [2:0] DefOffPeriods  = 3'd3;
  localparam logic [4:0] DefFalseLimit  = 5'd20;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_BEGIN   = 3'd1,
    ACT_APPEND  = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_RESET   = 3'd4,
    ACT_CONSUME = 3'd5
  } pdlm_action_e;

  typedef enum logic [1:0] {
    CFG_PERIOD_TICKS = 2'd0,
    CFG_ON_PERIODS   = 2'd1,
    CFG_OFF_PERIODS  = 2'd2,
    CFG_FALSE_LIMIT  = 2'd3
  } pdlm_cfg_idx_e;

  typedef struct packed {
    logic [7:0] period_ticks;
    logic [2:0] on_periods;
    logic [2:0] off_periods;
    logic [4:0] false_limit;
  } pdlm_cfg_t;

  typedef struct packed {
    logic       tx_pin;
    logic       power_pin;
    logic       rx_byte_valid;
    logic [7:0] rx_byte;
    logic       rx_packet_end;
    logic       packet_ready;
    logic       tx_busy;
    logic       rx_busy;
  } pdlm_result_t;

endpackage

FILE: src/power_data_line_master.sv
// power_data_line_master: top level with stream channels, config registers
// and assertions; depends on pdlm_pkg and pdlm_tick_core

// Master of a one-wire line that carries peripheral power and data.
// Input stream: one item per 10 us tick or host command. s_axis_tuser carries
// the action (tick, begin packet, append byte, send packet, request reset,
// consume ready packet); s_axis_tdata carries the sampled line level and the
// byte to append.
// Output stream: exactly one item per input item with pin levels, a received
// byte when one completes (m_axis_tlast marks the last byte of a packet) and
// the packet ready, tx busy and rx busy flags.
// Config channel: cfg_index_i picks period ticks, on periods, off periods or
// the false byte limit; always ready. The user sees that it is written only while
// the block is idle; the block itself leaves this unenforced.
// The input register feeds one pass of the tick logic into the result register.
// Throughput is one item per cycle while m_axis_tready holds, set by the single
// state update per item; the transmit queue read is prefetched into a register.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, then s_axis_tready drops.
// Reset (rst_ni low, asynchronous) clears all line state, empties both stages
// and restores the config defaults; the queue contents stay undefined.

module power_data_line_master import pdlm_pkg::*; #(
  parameter int unsigned TX_DEPTH = PdlmTxDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [0] line_level, [8:1] data_byte, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] tx_pin, [1] power_pin, [2] rx_byte_valid,
                                      // [10:3] rx_byte, [11] packet_ready,
                                      // [12] tx_busy, [13] rx_busy, rest zero
  output logic        m_axis_tlast,   // rx_packet_end
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  // input register
  logic         in_valid_q;
  pdlm_action_e in_action_q;
  logic         in_line_q;
  logic [7:0]   in_data_q;

  // result register
  logic         out_valid_q;
  pdlm_result_t out_q;

  pdlm_cfg_t    cfg_q;
  pdlm_result_t core_result;
  logic         core_fire;

  // the core advances when the result register is free or being drained
  assign core_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || core_fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= pdlm_action_e'(s_axis_tuser);
      in_line_q   <= s_axis_tdata[0];
      in_data_q   <= s_axis_tdata[8:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_fire) begin
      out_q <= core_result;
    end
  end

  // configuration registers, low bits of the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks <= DefPeriodTicks;
      cfg_q.on_periods   <= DefOnPeriods;
      cfg_q.off_periods  <= DefOffPeriods;
      cfg_q.false_limit  <= DefFalseLimit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pdlm_cfg_idx_e'(cfg_index_i))
        CFG_PERIOD_TICKS: cfg_q.period_ticks <= cfg_data_i;
        CFG_ON_PERIODS:   cfg_q.on_periods   <= cfg_data_i[2:0];
        CFG_OFF_PERIODS:  cfg_q.off_periods  <= cfg_data_i[2:0];
        CFG_FALSE_LIMIT:  cfg_q.false_limit  <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  pdlm_tick_core #(
    .TX_DEPTH(TX_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (core_fire),
    .action_i    (in_action_q),
    .line_level_i(in_line_q),
    .data_byte_i (in_data_q),
    .cfg_i       (cfg_q),
    .result_o    (core_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.rx_busy, out_q.tx_busy, out_q.packet_ready,
                          out_q.rx_byte, out_q.rx_byte_valid, out_q.power_pin,
                          out_q.tx_pin};
  assign m_axis_tlast  = out_q.rx_packet_end;

`ifndef SYNTH
  // a processed item always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_fire |=> out_valid_q)
    else $error("processed item did not reach the result register");

  // a held input item never waits behind an empty result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> core_fire)
    else $error("input stage stalled with free result register");

  // no received byte means byte and end mark are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.rx_byte_valid) |-> (out_q.rx_byte == 8'd0 && !out_q.rx_packet_end))
    else $error("rx byte fields set without a received byte");
`endif

endmodule

FILE: src/pdlm_tick_core.sv
// pdlm_tick_core: line state, slot sequencer, power divider and transmit queue
// advances one item per fire; depends on pdlm_pkg

module pdlm_tick_core import pdlm_pkg::*; #(
  parameter int unsigned TX_DEPTH = PdlmTxDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  pdlm_action_e action_i,
  input  logic         line_level_i,
  input  logic [7:0]   data_byte_i,
  input  pdlm_cfg_t    cfg_i,
  output pdlm_result_t result_o
);

  localparam int unsigned IdxW = $clog2(TX_DEPTH);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TX_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE       = 5'd0,
    ST_SET_BUSY   = 5'd2,
    ST_SET_NODE   = 5'd3,
    ST_SET_LAST   = 5'd5,
    ST_SET_BIT    = 5'd6,
    ST_CLEAR_NODE = 5'd7,
    ST_CHECK_PRPH = 5'd13,
    ST_CHECK_LAST = 5'd14,
    ST_CHECK_BIT  = 5'd15,
    ST_HIGH_SYNC  = 5'd17,
    ST_LOW_SYNC   = 5'd18,
    ST_CLEAR_SYNC = 5'd19
  } stage_e;

  stage_e          stage_q, stage_d;
  logic [6:0]      slot_cnt_q, slot_cnt_d;
  logic [7:0]      period_cnt_q, period_cnt_d;
  logic [2:0]      window_cnt_q, window_cnt_d;
  logic            power_on_q, power_on_d;
  logic            tx_pin_q, tx_pin_d;
  logic            power_pin_q, power_pin_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]      tx_sum_q, tx_sum_d;
  logic [7:0]      tx_shift_q, tx_shift_d;
  logic [3:0]      tx_bit_q, tx_bit_d;
  logic [7:0]      rx_shift_q, rx_shift_d;
  logic [3:0]      rx_bit_q, rx_bit_d;
  logic            f_rx_q, f_rx_d;
  logic            f_tx_q, f_tx_d;
  logic            f_last_rx_q, f_last_rx_d;
  logic            f_last_tx_q, f_last_tx_d;
  logic            f_ready_q, f_ready_d;
  logic            f_reset_req_q, f_reset_req_d;
  logic [4:0]      false_cnt_q, false_cnt_d;

  // queue storage, read data always mirrors the entry at rd_idx_q
  logic [7:0]      tx_mem [TX_DEPTH];
  logic [7:0]      rd_data_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [7:0]      mem_wdata;

  logic            out_valid;
  logic [7:0]      out_byte;
  logic            out_end;
  logic [6:0]      delay;
  logic [6:0]      slot_dec;
  logic [7:0]      period_inc;
  logic [2:0]      window_dec;
  logic [7:0]      rx_shift_new;
  logic [3:0]      rx_bit_new;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == IdxLast) ? '0 : idx + IdxW'(1);
  endfunction

  always_comb begin
    stage_d       = stage_q;
    slot_cnt_d    = slot_cnt_q;
    period_cnt_d  = period_cnt_q;
    window_cnt_d  = window_cnt_q;
    power_on_d    = power_on_q;
    tx_pin_d      = tx_pin_q;
    power_pin_d   = power_pin_q;
    wr_idx_d      = wr_idx_q;
    rd_idx_d      = rd_idx_q;
    tx_sum_d      = tx_sum_q;
    tx_shift_d    = tx_shift_q;
    tx_bit_d      = tx_bit_q;
    rx_shift_d    = rx_shift_q;
    rx_bit_d      = rx_bit_q;
    f_rx_d        = f_rx_q;
    f_tx_d        = f_tx_q;
    f_last_rx_d   = f_last_rx_q;
    f_last_tx_d   = f_last_tx_q;
    f_ready_d     = f_ready_q;
    f_reset_req_d = f_reset_req_q;
    false_cnt_d   = false_cnt_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_idx_q;
    mem_wdata     = data_byte_i;
    out_valid     = 1'b0;
    out_byte      = 8'd0;
    out_end       = 1'b0;
    delay         = Ticks80us;
    slot_dec      = slot_cnt_q - 7'd1;
    period_inc    = period_cnt_q + 8'd1;
    window_dec    = window_cnt_q - 3'd1;
    rx_shift_new  = rx_shift_q;
    rx_bit_new    = rx_bit_q + 4'd1;

    case (action_i)
      ACT_TICK: begin
        if (slot_cnt_q != 7'd0) begin
          slot_cnt_d = slot_dec;
          if (slot_dec == 7'd0) begin
            case (stage_q)
              ST_SET_BUSY: begin
                delay    = Ticks160us;
                tx_pin_d = f_rx_q | f_tx_q;
                stage_d  = ST_SET_NODE;
              end
              ST_SET_NODE: begin
                if (f_rx_q) begin
                  delay = Ticks520us; tx_pin_d = 1'b0; stage_d = ST_CHECK_LAST;
                end else if (f_tx_q) begin
                  delay = Ticks160us; tx_pin_d = 1'b1; stage_d = ST_CLEAR_NODE;
                end else if (f_reset_req_q) begin
                  f_reset_req_d = 1'b0;
                  delay = Ticks600us; tx_pin_d = 1'b1; stage_d = ST_HIGH_SYNC;
                end else begin
                  delay = Ticks380us; tx_pin_d = 1'b0; stage_d = ST_CHECK_PRPH;
                end
              end
              ST_CLEAR_NODE: begin
                delay = Ticks280us; tx_pin_d = 1'b0; stage_d = ST_SET_LAST;
              end
              ST_CHECK_PRPH: begin
                delay   = Ticks220us;
                stage_d = ST_HIGH_SYNC;
                if (!line_level_i) begin
                  f_rx_d     = 1'b1;
                  rx_bit_d   = 4'd0;
                  rx_shift_d = 8'd0;
                end
              end
              ST_SET_LAST: begin
                delay      = Ticks160us;
                tx_bit_d   = 4'd0;
                tx_shift_d = rd_data_q;
                rd_idx_d   = idx_inc(rd_idx_q);
                if (rd_idx_d == wr_idx_q) begin
                  tx_pin_d    = 1'b1;
                  f_last_tx_d = 1'b1;
                end else begin
                  tx_pin_d = 1'b0;
                end
                stage_d = ST_HIGH_SYNC;
              end
              ST_CHECK_LAST: begin
                delay       = Ticks80us;
                f_last_rx_d = ~line_level_i;
                stage_d     = ST_HIGH_SYNC;
              end
              ST_HIGH_SYNC: begin
                tx_pin_d = 1'b0; delay = Ticks80us; stage_d = ST_LOW_SYNC;
              end
              ST_LOW_SYNC: begin
                tx_pin_d = 1'b1; delay = Ticks80us; stage_d = ST_CLEAR_SYNC;
              end
              ST_CHECK_BIT: begin
                delay = Ticks160us;
                if (line_level_i) begin
                  rx_shift_new[rx_bit_q[2:0]] = 1'b1;
                end
                rx_shift_d = rx_shift_new;
                rx_bit_d   = rx_bit_new;
                if (rx_bit_new > 4'd7) begin
                  out_valid = 1'b1;
                  out_byte  = rx_shift_new;
                  out_end   = f_last_rx_q;
                  if (rx_shift_new == FalseByte) begin
                    if (false_cnt_q >= cfg_i.false_limit) f_rx_d = 1'b0;
                    if (false_cnt_q < FalseCountMax) false_cnt_d = false_cnt_q + 5'd1;
                  end
                  rx_shift_d = 8'd0;
                  rx_bit_d   = 4'd0;
                  delay      = TimerStop;
                  stage_d    = ST_IDLE;
                  if (f_last_rx_q) begin
                    f_last_rx_d = 1'b0;
                    f_ready_d   = 1'b1;
                    f_rx_d      = 1'b0;
                  end
                end
              end
              ST_CLEAR_SYNC, ST_SET_BIT: begin
                if (stage_q == ST_CLEAR_SYNC) tx_pin_d = 1'b0;
                if (stage_q == ST_CLEAR_SYNC && f_rx_q) begin
                  delay   = Ticks80us;
                  stage_d = ST_CHECK_BIT;
                end else if (stage_q == ST_SET_BIT || f_tx_q) begin
                  // one transmit bit slot, inverted drive
                  if (tx_bit_q < 4'd8) begin
                    tx_pin_d = ~tx_shift_q[tx_bit_q[2:0]];
                    tx_bit_d = tx_bit_q + 4'd1;
                    stage_d  = ST_SET_BIT;
                    delay    = Ticks160us;
                  end else begin
                    tx_pin_d = 1'b0;
                    stage_d  = ST_IDLE;
                    delay    = TimerStop;
                    if (f_last_tx_q) begin
                      f_tx_d      = 1'b0;
                      f_last_tx_d = 1'b0;
                    end
                  end
                end else begin
                  delay = TimerStop;
                end
              end
              default: begin
                stage_d = ST_IDLE;
              end
            endcase
            if (delay != TimerStop) slot_cnt_d = delay;
          end
        end
        // power divider, its window start overrides the sequencer
        period_cnt_d = period_inc;
        if (period_inc >= cfg_i.period_ticks) begin
          period_cnt_d = 8'd0;
          window_cnt_d = window_dec;
          if (window_dec == 3'd0) begin
            power_on_d = ~power_on_q;
            if (!power_on_q) begin
              window_cnt_d = cfg_i.on_periods;
              power_pin_d  = 1'b1;
              tx_pin_d     = 1'b0;
            end else begin
              window_cnt_d = cfg_i.off_periods;
              power_pin_d  = 1'b0;
              slot_cnt_d   = Ticks80us;
              stage_d      = ST_SET_BUSY;
              tx_pin_d     = 1'b1;
            end
          end
        end
      end
      ACT_BEGIN: begin
        if (!f_tx_q) begin
          rd_idx_d  = '0;
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = StartByte;
          tx_sum_d  = StartByte;
          wr_idx_d  = idx_inc('0);
        end
      end
      ACT_APPEND: begin
        if (!f_tx_q) begin
          mem_we    = 1'b1;
          mem_wdata = data_byte_i;
          tx_sum_d  = tx_sum_q + data_byte_i;
          wr_idx_d  = idx_inc(wr_idx_q);
        end
      end
      ACT_SEND: begin
        if (!f_tx_q) begin
          mem_we    = 1'b1;
          mem_wdata = tx_sum_q;
          tx_sum_d  = tx_sum_q + tx_sum_q;
          wr_idx_d  = idx_inc(wr_idx_q);
          f_tx_d    = 1'b1;
        end
      end
      ACT_RESET: begin
        f_reset_req_d = 1'b1;
      end
      ACT_CONSUME: begin
        if (f_ready_q) begin
          f_ready_d   = 1'b0;
          false_cnt_d = 5'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.tx_pin        = tx_pin_d;
    result_o.power_pin     = power_pin_d;
    result_o.rx_byte_valid = out_valid;
    result_o.rx_byte       = out_byte;
    result_o.rx_packet_end = out_end;
    result_o.packet_ready  = f_ready_d;
    result_o.tx_busy       = f_tx_d;
    result_o.rx_busy       = f_rx_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && mem_we) begin
      tx_mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read of the next read entry, bypassing a same cycle write
  logic [IdxW-1:0] rd_addr;
  assign rd_addr = fire_i ? rd_idx_d : rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (fire_i && mem_we && (mem_waddr == rd_addr)) begin
      rd_data_q <= mem_wdata;
    end else begin
      rd_data_q <= tx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q       <= ST_IDLE;
      slot_cnt_q    <= TimerStop;
      period_cnt_q  <= 8'd0;
      window_cnt_q  <= 3'd1;
      power_on_q    <= 1'b0;
      tx_pin_q      <= 1'b0;
      power_pin_q   <= 1'b0;
      wr_idx_q      <= '0;
      rd_idx_q      <= '0;
      tx_sum_q      <= 8'd0;
      tx_shift_q    <= 8'd0;
      tx_bit_q      <= 4'd0;
      rx_shift_q    <= 8'd0;
      rx_bit_q      <= 4'd0;
      f_rx_q        <= 1'b0;
      f_tx_q        <= 1'b0;
      f_last_rx_q   <= 1'b0;
      f_last_tx_q   <= 1'b0;
      f_ready_q     <= 1'b0;
      f_reset_req_q <= 1'b0;
      false_cnt_q   <= 5'd0;
    end else if (fire_i) begin
      stage_q       <= stage_d;
      slot_cnt_q    <= slot_cnt_d;
      period_cnt_q  <= period_cnt_d;
      window_cnt_q  <= window_cnt_d;
      power_on_q    <= power_on_d;
      tx_pin_q      <= tx_pin_d;
      power_pin_q   <= power_pin_d;
      wr_idx_q      <= wr_idx_d;
      rd_idx_q      <= rd_idx_d;
      tx_sum_q      <= tx_sum_d;
      tx_shift_q    <= tx_shift_d;
      tx_bit_q      <= tx_bit_d;
      rx_shift_q    <= rx_shift_d;
      rx_bit_q      <= rx_bit_d;
      f_rx_q        <= f_rx_d;
      f_tx_q        <= f_tx_d;
      f_last_rx_q   <= f_last_rx_d;
      f_last_tx_q   <= f_last_tx_d;
      f_ready_q     <= f_ready_d;
      f_reset_req_q <= f_reset_req_d;
      false_cnt_q   <= false_cnt_d;
    end
  end

endmodule
